FILE: hw/rtl/gda_pkg.sv
// Package for the Gregorian date adder: shared types, calendar constants
// and the month length function. No dependencies.
`default_nettype none

package gda_pkg;

    // Field and working widths
    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned ADD_W  = 15;
    localparam int unsigned REST_W = 16;   // day count, up to 366 + 32767

    // Calendar constants
    localparam logic [YEAR_W-1:0] C_YEAR_MAX = 14'd9999;
    localparam logic [YEAR_W-1:0] C_Q400     = 14'd400;
    localparam logic [YEAR_W-1:0] C_Q100     = 14'd100;
    localparam logic [YEAR_W-1:0] C_Q200     = 14'd200;
    localparam logic [YEAR_W-1:0] C_Q300     = 14'd300;
    localparam logic [YEAR_W-1:0] C_Q399     = 14'd399;
    localparam logic [MON_W-1:0]  C_MONTHS   = 4'd12;
    localparam logic [MON_W-1:0]  C_JAN      = 4'd1;
    localparam logic [REST_W-1:0] C_YEAR_LEN = 16'd365;
    localparam logic [REST_W-1:0] C_LEAP_LEN = 16'd366;

    // Shared arithmetic unit
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [REST_W-1:0] a;
        logic [REST_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [REST_W-1:0] res;
        logic              borrow;   // a < b on subtract
    } t_alu_rsp;

    // Days in month m; 0 for a month code outside 1..12
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MON_W-1:0] m,
                                                     input logic lp);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                                 len = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:              len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                len = 5'd31;
            default:                              len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gda_in_if.sv
// Input channel of the date adder: valid/ready plus the start date and day count.
// Depends on gda_pkg.
`default_nettype none

interface gda_in_if;
    import gda_pkg::*;

    logic              valid;
    logic              ready;
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
    logic [ADD_W-1:0]  days_to_add;

    modport source (
        output valid, start_day, start_month, start_year, days_to_add,
        input  ready
    );
    modport sink (
        input  valid, start_day, start_month, start_year, days_to_add,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/gda_out_if.sv
// Output channel of the date adder: valid/ready plus the result date and error flag.
// Depends on gda_pkg.
`default_nettype none

interface gda_out_if;
    import gda_pkg::*;

    logic              valid;
    logic              ready;
    logic [DAY_W-1:0]  end_day;
    logic [MON_W-1:0]  end_month;
    logic [YEAR_W-1:0] end_year;
    logic              bad_date;

    modport source (
        output valid, end_day, end_month, end_year, bad_date,
        input  ready
    );
    modport sink (
        input  valid, end_day, end_month, end_year, bad_date,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/gda_alu.sv
// Shared add/subtract unit of the date adder, used by every sequencer step.
// Depends on gda_pkg.
`default_nettype none

module gda_alu
    import gda_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [REST_W:0] w_sum;

    // One wide add or subtract; top bit is the borrow on subtract
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_sum = '0;
        endcase
    end

    assign o_rsp.res    = w_sum[REST_W-1:0];
    assign o_rsp.borrow = (i_req.op == ALU_SUB) && w_sum[REST_W];

endmodule

`default_nettype wire

FILE: hw/rtl/gregorian_date_add_days.sv
// Gregorian date plus a day count: sequencer and registers around one shared adder.
// Depends on gda_pkg, gda_in_if, gda_out_if and gda_alu.
//
// Usage:
//   i_in carries one transaction per date: start_day, start_month, start_year
//   and days_to_add. o_out returns one transaction per input: end_day,
//   end_month, end_year and bad_date. Both use valid/ready.
//   An invalid start date (day 0 or past month end, month outside 1..12,
//   year 0 or above 9999) sets bad_date and echoes the start date.
//   The sequencer walks from input transaction to o_out.valid in steps,
//   each one pass through the shared adder: year residue by 400, day add
//   with date check, month sums, whole-year walk and month walk.
//   One date is in work at a time; i_in.ready is high only while idle.
//   The result sits in an output register, so a new date is accepted while
//   the previous result waits; a stalled receiver holds the sequencer at its
//   last step once a second result is ready.
//   Reset (i_rst_n low, synchronous) returns to idle and drops o_out.valid.
`default_nettype none

module gregorian_date_add_days
    import gda_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MOD  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_MSUM = 7'b0001000,
        S_YEAR = 7'b0010000,
        S_MON  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [DAY_W-1:0]  r_day;
    logic [MON_W-1:0]  r_mon;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [YEAR_W-1:0] r_m400, n_m400;   // year mod 400 once reduced
    logic [REST_W-1:0] r_rest, n_rest;
    logic [MON_W-1:0]  r_k, n_k;         // month walk counter
    logic              r_bad, n_bad;

    logic              r_ov;
    logic [DAY_W-1:0]  r_o_day;
    logic [MON_W-1:0]  r_o_mon;
    logic [YEAR_W-1:0] r_o_year;
    logic              r_o_bad;

    t_alu_req          w_req;
    t_alu_rsp          w_rsp;
    logic              w_leap;
    logic              w_invalid;
    logic              w_fits;
    logic              w_out_free;
    logic [DAY_W-1:0]  w_len_k;

    gda_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // Leap year from low year bits and residue by 400
    assign w_leap = (r_year[1:0] == 2'b00) && (r_m400 != C_Q100) &&
                    (r_m400 != C_Q200) && (r_m400 != C_Q300);

    assign w_invalid = (r_mon == '0) || (r_mon > C_MONTHS) || (r_day == '0) ||
                       (r_year == '0) || (r_year > C_YEAR_MAX) ||
                       (r_day > f_month_len(r_mon, w_leap));

    assign w_len_k    = f_month_len(r_k, w_leap);
    // Subtract result taken when rest was strictly larger than the length
    assign w_fits     = w_rsp.borrow || (w_rsp.res == '0);
    assign w_out_free = !r_ov || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);

    // Shared adder operand selection
    always_comb begin
        w_req.op = ALU_SUB;
        w_req.a  = r_rest;
        w_req.b  = '0;
        unique case (r_state)
            S_MOD: begin
                w_req.a = {{(REST_W-YEAR_W){1'b0}}, r_m400};
                w_req.b = {{(REST_W-YEAR_W){1'b0}}, C_Q400};
            end
            S_CHK: begin
                w_req.op = ALU_ADD;
                w_req.b  = {{(REST_W-DAY_W){1'b0}}, r_day};
            end
            S_MSUM: begin
                w_req.op = ALU_ADD;
                w_req.b  = {{(REST_W-DAY_W){1'b0}}, w_len_k};
            end
            S_YEAR: begin
                w_req.b = w_leap ? C_LEAP_LEN : C_YEAR_LEN;
            end
            S_MON: begin
                w_req.b = {{(REST_W-DAY_W){1'b0}}, w_len_k};
            end
            default: begin
                w_req.a = r_rest;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_year  = r_year;
        n_m400  = r_m400;
        n_rest  = r_rest;
        n_k     = r_k;
        n_bad   = r_bad;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_rsp.borrow) begin
                    n_state = S_CHK;
                end else begin
                    n_m400 = w_rsp.res[YEAR_W-1:0];
                end
            end
            S_CHK: begin
                n_bad = w_invalid;
                n_k   = C_JAN;
                if (w_invalid) begin
                    n_state = S_DONE;
                end else begin
                    n_rest  = w_rsp.res;
                    n_state = S_MSUM;
                end
            end
            S_MSUM: begin
                if (r_k == r_mon) begin
                    n_state = S_YEAR;
                end else begin
                    n_rest = w_rsp.res;
                    n_k    = r_k + 4'd1;
                end
            end
            S_YEAR: begin
                if (w_fits) begin
                    n_k     = C_JAN;
                    n_state = S_MON;
                end else begin
                    n_rest = w_rsp.res;
                    n_year = r_year + 14'd1;
                    n_m400 = (r_m400 == C_Q399) ? '0 : r_m400 + 14'd1;
                end
            end
            S_MON: begin
                if (w_fits) begin
                    n_state = S_DONE;
                end else begin
                    n_rest = w_rsp.res;
                    n_k    = r_k + 4'd1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers; load on input transaction
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_day  <= i_in.start_day;
            r_mon  <= i_in.start_month;
            r_year <= i_in.start_year;
            r_m400 <= i_in.start_year;
            r_rest <= {{(REST_W-ADD_W){1'b0}}, i_in.days_to_add};
            r_k    <= C_JAN;
            r_bad  <= 1'b0;
        end else begin
            r_year <= n_year;
            r_m400 <= n_m400;
            r_rest <= n_rest;
            r_k    <= n_k;
            r_bad  <= n_bad;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_bad  <= r_bad;
            r_o_year <= r_year;
            if (r_bad) begin
                r_o_day <= r_day;
                r_o_mon <= r_mon;
            end else begin
                r_o_day <= r_rest[DAY_W-1:0];
                r_o_mon <= r_k;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.end_day   = r_o_day;
    assign o_out.end_month = r_o_mon;
    assign o_out.end_year  = r_o_year;
    assign o_out.bad_date  = r_o_bad;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_MOD))
        else $error("accepted transaction did not start the residue step");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR || r_state == S_MON || r_state == S_MSUM) |->
        (r_m400 < C_Q400))
        else $error("year residue not reduced below 400");

    a_month_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MON) |-> (r_k >= C_JAN && r_k <= C_MONTHS))
        else $error("month walk ran outside January..December");

    a_good_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.bad_date) |->
        (o_out.end_day != '0 && o_out.end_month >= C_JAN &&
         o_out.end_month <= C_MONTHS))
        else $error("valid result holds an impossible date");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !w_out_free) |=> (r_state == S_DONE && !i_in.ready))
        else $error("finished result dropped while output stalled");

endmodule

`default_nettype wire

FILE: tb/gregorian_date_add_days_checker.sv
// Scoreboard for the Gregorian date adder: watches both channels, predicts each
// result date from the accepted start date and day count, and compares in order.
// Depends on gda_pkg, gda_in_if and gda_out_if.
`default_nettype none

module gregorian_date_add_days_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    gda_in_if    i_in_ch,
    gda_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gda_pkg::*;

    localparam int unsigned FEB = 2;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic              bad;
    } date_result_t;

    date_result_t end_dates_q[$];
    date_result_t want;
    int           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = end_dates_q.size();

    // Leap rule: divisible by 4 and not by 100, or divisible by 400
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    // Month length in a given year; 0 for a month code outside 1..12
    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            FEB:                       len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:               len = 30;
            1, 3, 5, 7, 8, 10, 12:     len = 31;
            default:                   len = 0;
        endcase
        return len;
    endfunction

    // Date plus day count: day of year, then walk whole years, then months
    function automatic date_result_t add_days_to_date(input logic [DAY_W-1:0]  d,
                                                      input logic [MON_W-1:0]  m,
                                                      input logic [YEAR_W-1:0] y,
                                                      input logic [ADD_W-1:0]  add);
        date_result_t r;
        int unsigned  rest;
        int unsigned  yr;
        int unsigned  mo;
        int unsigned  ylen;
        r.day   = d;
        r.month = m;
        r.year  = y;
        r.bad   = 1'b1;
        // invalid start date echoes the input with the error flag
        if (m < C_JAN || m > C_MONTHS || d == 0 || y == 0 || y > C_YEAR_MAX ||
            d > days_in(m, y))
            return r;
        yr   = y;
        rest = d;
        for (mo = C_JAN; mo < m; mo++)
            rest += days_in(mo, yr);
        rest += add;
        ylen = is_leap(yr) ? C_LEAP_LEN : C_YEAR_LEN;
        while (rest > ylen) begin
            rest -= ylen;
            yr++;
            ylen = is_leap(yr) ? C_LEAP_LEN : C_YEAR_LEN;
        end
        mo = C_JAN;
        while (rest > days_in(mo, yr)) begin
            rest -= days_in(mo, yr);
            mo++;
        end
        r.day   = rest[DAY_W-1:0];
        r.month = mo[MON_W-1:0];
        r.year  = yr[YEAR_W-1:0];
        r.bad   = 1'b0;
        return r;
    endfunction

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_ch.valid && i_in_ch.ready)
                end_dates_q.push_back(add_days_to_date(i_in_ch.start_day,
                                                       i_in_ch.start_month,
                                                       i_in_ch.start_year,
                                                       i_in_ch.days_to_add));
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (end_dates_q.size() == 0) begin
                    $error("result transaction with no start date pending");
                    fail_count++;
                end else begin
                    want = end_dates_q.pop_front();
                    if (i_out_ch.end_day !== want.day) begin
                        $error("end_day expected %0d got %0d", want.day, i_out_ch.end_day);
                        fail_count++;
                    end
                    if (i_out_ch.end_month !== want.month) begin
                        $error("end_month expected %0d got %0d", want.month,
                               i_out_ch.end_month);
                        fail_count++;
                    end
                    if (i_out_ch.end_year !== want.year) begin
                        $error("end_year expected %0d got %0d", want.year, i_out_ch.end_year);
                        fail_count++;
                    end
                    if (i_out_ch.bad_date !== want.bad) begin
                        $error("bad_date expected %0d got %0d", want.bad, i_out_ch.bad_date);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/gregorian_date_add_days_tb.sv
// Top of the date adder testbench: clock, reset, directed and random start dates,
// random receiver stalls and the verdict.
// Depends on gda_pkg, gda_in_if, gda_out_if, the RTL and gregorian_date_add_days_checker.
`default_nettype none

module gregorian_date_add_days_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gda_pkg::*;

    localparam int unsigned N_RANDOM   = 540;
    localparam int unsigned DRAIN_CYC  = 400;   // well past the worst-case latency

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   steady  = 1'b0;   // when set, neither side idles
    int   fail_count;
    int   pending;

    gda_in_if  in_ch ();
    gda_out_if out_ch ();

    gregorian_date_add_days dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gregorian_date_add_days_checker date_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop; a correct run takes a small fraction of this
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one start date after a random gap and hold it until accepted
    task automatic send_date(input logic [DAY_W-1:0]  d,
                             input logic [MON_W-1:0]  m,
                             input logic [YEAR_W-1:0] y,
                             input logic [ADD_W-1:0]  add);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid       = 1'b0;
            in_ch.start_day   = DAY_W'($urandom);
            in_ch.start_month = MON_W'($urandom);
            in_ch.start_year  = YEAR_W'($urandom);
            in_ch.days_to_add = ADD_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.start_day   = d;
        in_ch.start_month = m;
        in_ch.start_year  = y;
        in_ch.days_to_add = add;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Receiver: random stall before each result transaction
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            @(negedge i_clk);
            if (stall != 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Stimulus and verdict
    initial begin
        int unsigned       k;
        logic [DAY_W-1:0]  d;
        logic [MON_W-1:0]  m;
        logic [YEAR_W-1:0] y;
        logic [ADD_W-1:0]  add;

        in_ch.valid       = 1'b0;
        in_ch.start_day   = '0;
        in_ch.start_month = '0;
        in_ch.start_year  = '0;
        in_ch.days_to_add = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, leap rules, year and month rollover, bad dates
        send_date(5'd1,  4'd1,  14'd1,     15'd0);
        send_date(5'd31, 4'd12, 14'd9999,  15'd32767);
        send_date(5'd1,  4'd1,  14'd1,     15'd32767);
        send_date(5'd31, 4'd12, 14'd2023,  15'd1);
        send_date(5'd29, 4'd2,  14'd2000,  15'd1);
        send_date(5'd29, 4'd2,  14'd2024,  15'd365);
        send_date(5'd29, 4'd2,  14'd1900,  15'd0);
        send_date(5'd29, 4'd2,  14'd2023,  15'd5);
        send_date(5'd28, 4'd2,  14'd1900,  15'd1);
        send_date(5'd31, 4'd12, 14'd1999,  15'd60);
        send_date(5'd1,  4'd1,  14'd2000,  15'd365);
        send_date(5'd1,  4'd1,  14'd2100,  15'd59);
        send_date(5'd31, 4'd4,  14'd2010,  15'd3);
        send_date(5'd30, 4'd2,  14'd2000,  15'd3);
        send_date(5'd0,  4'd6,  14'd2010,  15'd3);
        send_date(5'd15, 4'd0,  14'd2010,  15'd3);
        send_date(5'd15, 4'd13, 14'd2010,  15'd3);
        send_date(5'd31, 4'd15, 14'd16383, 15'd32767);
        send_date(5'd15, 4'd6,  14'd0,     15'd3);
        send_date(5'd15, 4'd6,  14'd10000, 15'd3);
        send_date(5'd31, 4'd1,  14'd16383, 15'd0);
        send_date(5'd30, 4'd11, 14'd9999,  15'd31);
        send_date(5'd31, 4'd7,  14'd400,   15'd16384);
        send_date(5'd1,  4'd8,  14'd8191,  15'd21845);

        // Random: mostly valid dates, some broken days, years above 9999, and raw noise
        for (k = 0; k < N_RANDOM; k++) begin
            steady = ((k / 60) % 3) == 2;
            case ($urandom_range(0, 2))
                0:       y = 14'($urandom_range(1, 99) * 100 - $urandom_range(0, 1));
                1:       y = 14'($urandom_range(9900, 9999));
                default: y = 14'($urandom_range(1, 9999));
            endcase
            m = 4'($urandom_range(1, 12));
            d = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 28))
                                           : 5'($urandom_range(28, 31));
            case ($urandom_range(0, 9))
                0:       add = 15'($urandom_range(0, 32767));
                1:       add = 15'($urandom_range(32000, 32767));
                2:       add = '0;
                default: add = 15'($urandom_range(0, 1500));
            endcase
            case ($urandom_range(0, 19))
                0, 1: begin
                    d = DAY_W'($urandom);
                    m = MON_W'($urandom);
                    y = YEAR_W'($urandom);
                end
                2:       y = 14'($urandom_range(10000, 16383));
                default: ;
            endcase
            send_date(d, m, y, add);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        steady      = 1'b0;

        // Drain: wait for every result, then watch for stray ones
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
